[rtl/core/line_strip_screen_distance_defines.svh]
// assertion macros for the line strip screen distance block
// expects clk and rst_n in the scope of every use
`ifndef LINE_STRIP_SCREEN_DISTANCE_DEFINES_SVH
`define LINE_STRIP_SCREEN_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define LSSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssd check failed");
`define LSSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssd check failed");
`else
`define LSSD_ASSERT_NEXT(label, ante, cons)
`define LSSD_ASSERT_NOW(label, ante, cons)
`endif
`endif

[rtl/core/lssd_pkg.sv]
// shared types and constants of the line strip screen distance block
// no dependencies
package lssd_pkg;

    localparam int MAC_STEPS  = 12;
    localparam int DIV_STEPS  = 50;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W      = 6;
    localparam int CLIP_W     = 34;
    localparam int DVD_W      = 50;
    localparam int REM_W      = 35;

    localparam logic [2:0] REG_ROW_X  = 3'd0;
    localparam logic [2:0] REG_ROW_Y  = 3'd1;
    localparam logic [2:0] REG_ROW_W  = 3'd2;
    localparam logic [2:0] REG_HALF_W = 3'd3;
    localparam logic [2:0] REG_HALF_H = 3'd4;

    localparam logic [63:0] ROW_X_RESET = 64'd1024;
    localparam logic [63:0] ROW_Y_RESET = 64'd1024 << 16;
    localparam logic [63:0] ROW_W_RESET = 64'd1024 << 48;
    localparam logic [11:0] HALF_W_RESET = 12'd400;
    localparam logic [11:0] HALF_H_RESET = 12'd300;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SCALE,
        ST_DIV,
        ST_MAP,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAC,
        OP_SCALE,
        OP_DIV,
        OP_MAP,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_ROOT,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic       axis;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic start;
    } status_t;

endpackage

[rtl/core/lssd_ctrl.sv]
// sequencer of the line strip screen distance block
// depends on lssd_pkg
module lssd_ctrl
    import lssd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             axis_reg, axis_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (cnt_reg == CNT_W'(MAC_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                    axis_next  = 1'b0;
                end
            end
            ST_SCALE:
            begin
                // clip w is only registered once the mac is done
                state_next = status.bad ? ST_DONE : ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_SCALE;
                end
                else
                    state_next = status.start ? ST_DONE : ST_DIFF;
            end
            ST_DIFF: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:
            begin
                state_next = ST_ROOT;
                cnt_next   = '0;
            end
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.idx  = cnt_reg[3:0];
        cmd.axis = axis_reg;
        case (state_reg)
            ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_CLIP:  cmd.op = OP_MAC;
            ST_SCALE: cmd.op = OP_SCALE;
            ST_DIV:   cmd.op = OP_DIV;
            ST_MAP:   cmd.op = OP_MAP;
            ST_DIFF:  cmd.op = OP_DIFF;
            ST_SQX:   cmd.op = OP_SQX;
            ST_SQY:   cmd.op = OP_SQY;
            ST_ROOT:  cmd.op = OP_ROOT;
            ST_DONE:  cmd.op = slot_free ? OP_FINISH : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_FINISH)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/lssd_datapath.sv]
// arithmetic of the line strip screen distance block: mac, divider, root
// depends on lssd_pkg
module lssd_datapath
    import lssd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [63:0]        row_x,
    input  logic [63:0]        row_y,
    input  logic [63:0]        row_w,
    input  logic [11:0]        half_w,
    input  logic [11:0]        half_h,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               strip_start,
    output status_t            status,
    output logic [31:0]        path_length,
    output logic               bad_depth
);

    localparam int SUM_W = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

    // item payload
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic               start_reg;
    logic [31:0]        shown_reg;
    // clip values
    logic signed [CLIP_W-1:0] acc_reg, cx_reg, cy_reg, cw_reg;
    // divider
    logic [DVD_W-1:0] dvd_reg;
    logic [REM_W-1:0] rem_reg;
    logic             neg_reg;
    // screen points
    logic signed [31:0] sx_reg, sy_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg;
    // length
    logic [31:0] ax_reg, ay_reg;
    logic [63:0] sq_reg, v_reg, res_reg, bit_reg;
    logic [LENGTH_BITS-1:0] run_reg;
    logic [31:0] path_length_reg;
    logic        bad_depth_reg;

    // mac operands
    logic [63:0]        row_sel;
    logic signed [15:0] coef, coord;
    logic signed [31:0] prod;
    logic signed [CLIP_W-1:0] acc_sum;

    always_comb
    begin
        case (cmd.idx[3:2])
            2'd0:    row_sel = row_x;
            2'd1:    row_sel = row_y;
            default: row_sel = row_w;
        endcase
        coef = row_sel[16*cmd.idx[1:0] +: 16];
        case (cmd.idx[1:0])
            2'd0:    coord = px_reg;
            2'd1:    coord = py_reg;
            2'd2:    coord = pz_reg;
            default: coord = 16'sd16384;
        endcase
        prod    = coef * coord;
        acc_sum = ((cmd.idx[1:0] == 2'd0) ? CLIP_W'(0) : acc_reg) + CLIP_W'(prod);
    end

    // scaling by half size
    logic signed [CLIP_W-1:0] c_sel;
    logic [11:0]              half_sel;
    logic signed [46:0]       num;
    logic [45:0]              mag;

    always_comb
    begin
        c_sel    = cmd.axis ? cy_reg : cx_reg;
        half_sel = cmd.axis ? half_h : half_w;
        num      = c_sel * $signed({1'b0, half_sel});
        mag      = num[46] ? 46'(-num) : 46'(num);
    end

    // one restoring division step
    logic [REM_W:0] rem_ext;
    logic [REM_W:0] w_ext;
    logic           qbit;

    always_comb
    begin
        rem_ext = {rem_reg, dvd_reg[DVD_W-1]};
        w_ext   = (REM_W+1)'(cw_reg);
        qbit    = (rem_ext >= w_ext);
    end

    // map quotient to pixels with saturation
    logic signed [51:0] base, scr;
    logic signed [31:0] scr_sat;

    always_comb
    begin
        base = 52'($unsigned({half_sel, 4'b0000}));
        scr  = neg_reg ? base - 52'(dvd_reg) : base + 52'(dvd_reg);
        if (scr > 52'sd1073741823)
            scr_sat = 32'sd1073741823;
        else if (scr < -52'sd1073741824)
            scr_sat = -32'sd1073741824;
        else
            scr_sat = scr[31:0];
    end

    // edge deltas
    logic signed [32:0] dx, dy;

    always_comb
    begin
        dx = 33'(sx_reg) - 33'(prev_x_reg);
        dy = 33'(sy_reg) - 33'(prev_y_reg);
    end

    // root step
    logic [63:0] trial;
    logic        take;

    always_comb
    begin
        trial = res_reg + bit_reg;
        take  = (v_reg >= trial);
    end

    // running sum and shown value
    logic [SUM_W-1:0] run_ext, sum_full;
    logic [LENGTH_BITS-1:0] run_sat;
    logic [31:0] shown_now;

    always_comb
    begin
        run_ext   = SUM_W'(run_reg);
        sum_full  = run_ext + SUM_W'(res_reg[31:0]);
        run_sat   = (|sum_full[SUM_W-1:LENGTH_BITS]) ? '1 : sum_full[LENGTH_BITS-1:0];
        shown_now = (|run_ext[SUM_W-1:32]) ? 32'hFFFF_FFFF : run_ext[31:0];
    end

    // state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            run_reg    <= '0;
        end
        else if (cmd.op == OP_LOAD && strip_start)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            run_reg    <= '0;
        end
        else if (cmd.op == OP_FINISH && !status.bad)
        begin
            if (!start_reg)
                run_reg <= run_sat;
            prev_x_reg <= sx_reg;
            prev_y_reg <= sy_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                px_reg    <= pos_x;
                py_reg    <= pos_y;
                pz_reg    <= pos_z;
                start_reg <= strip_start;
                shown_reg <= strip_start ? 32'd0 : shown_now;
            end
            OP_MAC:
            begin
                acc_reg <= acc_sum;
                if (cmd.idx[1:0] == 2'd3)
                begin
                    case (cmd.idx[3:2])
                        2'd0:    cx_reg <= acc_sum;
                        2'd1:    cy_reg <= acc_sum;
                        default: cw_reg <= acc_sum;
                    endcase
                end
            end
            OP_SCALE:
            begin
                neg_reg <= num[46];
                dvd_reg <= {mag, 4'b0000} + DVD_W'(cw_reg >>> 1);
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= qbit ? REM_W'(rem_ext - w_ext) : REM_W'(rem_ext);
                dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            end
            OP_MAP:
            begin
                if (cmd.axis)
                    sy_reg <= scr_sat;
                else
                    sx_reg <= scr_sat;
            end
            OP_DIFF:
            begin
                ax_reg <= dx[32] ? 32'(-dx) : dx[31:0];
                ay_reg <= dy[32] ? 32'(-dy) : dy[31:0];
            end
            OP_SQX:
                sq_reg <= ax_reg * ax_reg;
            OP_SQY:
            begin
                v_reg   <= sq_reg + ay_reg * ay_reg;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            OP_ROOT:
            begin
                if (take)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_FINISH:
            begin
                path_length_reg <= shown_reg;
                bad_depth_reg   <= status.bad;
            end
            default: ;
        endcase
    end

    assign status.bad   = (cw_reg <= 0);
    assign status.start = start_reg;
    assign path_length  = path_length_reg;
    assign bad_depth    = bad_depth_reg;

endmodule

[rtl/core/line_strip_screen_distance.sv]
// per vertex: clip mac, two axis divides on one shared radix-2 divider, edge difference,
// squaring, integer root and the output step, then its result beat
// a strip start skips the length steps, a bad depth stops after the clip
// a vertex is taken only once the last is finished; a stalled result beat holds the
// controller, the finished beat sits in an output register while the next vertex is taken
// reset: async, active low; registers to defaults, point and length to zero; uses lssd_pkg
`include "line_strip_screen_distance_defines.svh"
module line_strip_screen_distance
    import lssd_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // vertex beats
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               strip_start,
    // result beats
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        path_length,
    output logic               bad_depth
);

    // configuration registers, one every eight bytes
    logic [63:0] row_x_reg, row_y_reg, row_w_reg;
    logic [11:0] half_w_reg, half_h_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= ROW_X_RESET;
            row_y_reg  <= ROW_Y_RESET;
            row_w_reg  <= ROW_W_RESET;
            half_w_reg <= HALF_W_RESET;
            half_h_reg <= HALF_H_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_X:  row_x_reg  <= pwdata;
                REG_ROW_Y:  row_y_reg  <= pwdata;
                REG_ROW_W:  row_w_reg  <= pwdata;
                REG_HALF_W: half_w_reg <= pwdata[11:0];
                REG_HALF_H: half_h_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_ROW_X:  prdata = row_x_reg;
            REG_ROW_Y:  prdata = row_y_reg;
            REG_ROW_W:  prdata = row_w_reg;
            REG_HALF_W: prdata = 64'(half_w_reg);
            REG_HALF_H: prdata = 64'(half_h_reg);
            default:    prdata = '0;
        endcase
    end

    // controller and datapath talk only through these
    cmd_t    cmd;
    status_t status;

    lssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lssd_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .row_x       (row_x_reg),
        .row_y       (row_y_reg),
        .row_w       (row_w_reg),
        .half_w      (half_w_reg),
        .half_h      (half_h_reg),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .strip_start (strip_start),
        .status      (status),
        .path_length (path_length),
        .bad_depth   (bad_depth)
    );

    // a taken vertex keeps the block busy for the next cycle
    `LSSD_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    // a result beat only appears at the end of a vertex's work
    `LSSD_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
    // nothing new starts while the controller is still working
    `LSSD_ASSERT_NOW(a_no_load_when_busy, in_stall, cmd.op != OP_LOAD)

endmodule

[verif/lssd_checker.sv]
// vertex/result beat monitor: predicts the running screen length of each vertex
// and compares it with the block's result beats; depends on lssd_pkg only
module lssd_checker
    import lssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               strip_start,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [31:0]        path_length,
    input  logic               bad_depth,
    output int                 fail_count,
    output int                 pending
);
    typedef struct packed {
        logic [31:0] path;
        logic        bad;
    } length_beat_t;

    localparam longint SCR_MAX = 64'sd1073741823;
    localparam longint SCR_MIN = -64'sd1073741824;

    length_beat_t length_q[$];
    logic [63:0] row_x, row_y, row_w;
    logic [11:0] half_w, half_h;
    longint      last_sx, last_sy;
    logic [63:0] strip_len;

    function automatic longint clip_val(logic [63:0] row, longint px, longint py, longint pz);
        return longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
             + longint'($signed(row[47:32])) * pz + longint'($signed(row[63:48])) * 16384;
    endfunction

    function automatic longint to_pixels(longint c, longint w, logic [11:0] half);
        longint num, s;
        logic [63:0] mag, q;
        num = c * longint'(half) * 16;
        mag = num < 0 ? -num : num;
        q = (mag + w / 2) / w;
        s = longint'(half) * 16 + (num < 0 ? -longint'(q) : longint'(q));
        if (s > SCR_MAX) s = SCR_MAX;
        if (s < SCR_MIN) s = SCR_MIN;
        return s;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_vertex();
        longint px, py, pz, cx, cy, cw, sx, sy, dx, dy;
        logic [63:0] d, sum;
        length_beat_t e;
        px = pos_x; py = pos_y; pz = pos_z;
        cx = clip_val(row_x, px, py, pz);
        cy = clip_val(row_y, px, py, pz);
        cw = clip_val(row_w, px, py, pz);
        if (strip_start) begin
            strip_len = 0; last_sx = 0; last_sy = 0;
        end
        e.path = strip_len > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : strip_len[31:0];
        e.bad = cw <= 0;
        if (!e.bad) begin
            sx = to_pixels(cx, cw, half_w);
            sy = to_pixels(cy, cw, half_h);
            if (!strip_start) begin
                dx = sx - last_sx; dy = sy - last_sy;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                d = int_root(dx * dx + dy * dy);
                sum = strip_len + d;
                strip_len = sum > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sum;
            end
            last_sx = sx; last_sy = sy;
        end
        length_q.push_back(e);
    endtask

    assign pending = length_q.size();

    always @(posedge clk or negedge rst_n) begin
        length_beat_t e;
        if (!rst_n) begin
            row_x <= ROW_X_RESET; row_y <= ROW_Y_RESET; row_w <= ROW_W_RESET;
            half_w <= HALF_W_RESET; half_h <= HALF_H_RESET;
            last_sx = 0; last_sy = 0; strip_len = 0;
            fail_count <= 0;
            length_q.delete();
        end
        else begin
            // register writes land on the access cycle
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_ROW_X:  row_x <= pwdata;
                    REG_ROW_Y:  row_y <= pwdata;
                    REG_ROW_W:  row_w <= pwdata;
                    REG_HALF_W: half_w <= pwdata[11:0];
                    REG_HALF_H: half_h <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) predict_vertex();
            if (out_valid && !out_stall) begin
                if (length_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result beat %h %b",
                                                  path_length, bad_depth);
                end
                else begin
                    e = length_q.pop_front();
                    if (e.path !== path_length || e.bad !== bad_depth) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp len %h bad %b, got len %h bad %b",
                                     e.path, e.bad, path_length, bad_depth);
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// stimulus and verdict for the line strip screen distance block
// depends on lssd_pkg, the block itself and lssd_checker
module tb_top;
    import lssd_pkg::*;

    logic               clk, rst_n;
    logic               psel, penable, pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata, prdata;
    logic               pready;
    logic               in_valid, in_stall;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic               strip_start;
    logic               out_valid, out_stall;
    logic [31:0]        path_length;
    logic               bad_depth;
    int                 fail_count, pending;
    int                 quiet_cycles;
    bit                 long_hold;

    localparam int QUIET_LIMIT = 20000;

    line_strip_screen_distance uut (.*);

    lssd_checker chk (.*);

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // watchdog: a run of cycles with no beat on either side means a hang
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls on its own pattern; one long hold-off to back the block up
    initial begin
        int mode;
        out_stall <= 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1;
                repeat (600) @(posedge clk);
                long_hold = 0;
                out_stall <= 0;
            end
            else begin
                mode = $urandom_range(0, 9);
                out_stall <= mode < 3 ? ($urandom_range(0, 3) != 0) : (mode < 5 ? 1'b1 : 1'b0);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // one vertex beat: hold valid until taken, keep valid up for back-to-back beats
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic s);
        in_valid <= 1; pos_x <= x; pos_y <= y; pos_z <= z; strip_start <= s;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic gap();
        int n;
        // sender bursts: usually no gap, sometimes a random one
        if ($urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            n = $urandom_range(1, 60);
            repeat (n) @(posedge clk);
        end
    endtask

    // wait for the block to drain before touching registers
    task automatic drain();
        @(posedge clk);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_coef();
        int k;
        k = $urandom_range(0, 5);
        case (k)
            0: return 16'h0400;
            1: return 16'hFC00;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 16'h07FF));
            4: return 16'(-$urandom_range(0, 16'h07FF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_strips(int count);
        int sent;
        logic [15:0] x, y, z;
        sent = 0;
        while (sent < count) begin
            // mostly well-formed strips, some odd starts mid-way
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                x = $signed(x) >>> $urandom_range(0, 4);
                y = $signed(y) >>> $urandom_range(0, 4);
            end
            send_vertex(x, y, z, $urandom_range(0, 11) == 0);
            gap();
            sent++;
        end
    endtask

    initial begin
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
        in_valid <= 0; pos_x <= 0; pos_y <= 0; pos_z <= 0; strip_start <= 0;
        long_hold = 0;
        rst_n <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, field extremes, strip start, bad depth
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 0);
        send_vertex(16'h4000, 16'hC000, 16'h0000, 0);
        send_vertex(16'h2000, 16'h2000, 16'h1234, 1);
        send_vertex(16'hE000, 16'h1000, 16'h0000, 0);
        drain();
        // w from z: negative and zero depth
        reg_write(REG_ROW_W, 64'h0000_0400_0000_0000);
        send_vertex(16'h1000, 16'h1000, 16'h0000, 0);
        send_vertex(16'h1000, 16'h1000, 16'hC000, 0);
        send_vertex(16'h1000, 16'h2000, 16'hC000, 1);
        send_vertex(16'h1000, 16'h2000, 16'h0001, 0);
        send_vertex(16'hF000, 16'h3000, 16'h4000, 0);
        drain();
        // tiny w with huge coefficients drives the screen clamp; max viewport
        reg_write(REG_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
        reg_write(REG_ROW_Y, 64'h8000_8000_8000_8000);
        reg_write(REG_HALF_W, 64'd4095);
        reg_write(REG_HALF_H, 64'd4095);
        send_vertex(16'h0001, 16'h0000, 16'h0000, 1);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h0001, 0);
        send_vertex(16'h8000, 16'h8000, 16'h7FFF, 0);
        send_vertex(16'h0001, 16'h0001, 16'h0001, 0);
        drain();
        // minimum and zero viewport
        reg_write(REG_HALF_W, 64'd1);
        reg_write(REG_HALF_H, 64'd0);
        send_vertex(16'h3000, 16'h3000, 16'h3000, 0);
        send_vertex(16'hD000, 16'h2000, 16'h1000, 0);
        drain();

        // random phases; one of them runs with a long receiver hold-off
        for (int ph = 0; ph < 9; ph++) begin
            reg_write(REG_ROW_X, {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()});
            reg_write(REG_ROW_Y, {rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef()});
            reg_write(REG_ROW_W, {16'(16'h0400 + $urandom_range(0, 16'h0C00)),
                                  rnd_coef() >>> 3, rnd_coef() >>> 3, rnd_coef() >>> 3});
            reg_write(REG_HALF_W, $urandom_range(0, 1) ? 64'd4095 : $urandom_range(1, 4095));
            reg_write(REG_HALF_H, $urandom_range(0, 1) ? 64'd1 : $urandom_range(1, 4095));
            if (ph == 3) long_hold = 1;
            random_strips(145);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
